// File: rtl/zkt_pkg.sv
// ----------------------------------------------------------------------------
// zkt_pkg
// Shared constants and types of the Zobrist key table: generator constants,
// default table sizes, stream kinds, fill states and phases and write strobes.
// ----------------------------------------------------------------------------
package zkt_pkg;

  // Minimal standard generator
  localparam logic [14:0] MS_A = 15'd16807;
  localparam logic [30:0] MS_M = 31'h7fff_ffff;

  // Default table geometry
  localparam int NUM_SQUARES_DEF     = 128;
  localparam int NUM_PIECE_TYPES_DEF = 8;

  // Stream kinds carried in tuser on the input side
  localparam logic OP_FILL   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    FILL_IDLE,
    FILL_STEP,
    FILL_WAIT,
    FILL_STORE
  } fill_state_t;

  typedef enum logic [1:0] {
    PH_TURN,
    PH_MAIN,
    PH_EP
  } fill_phase_t;

  // Write strobes from the fill sequencer to the key stores
  typedef struct packed {
    logic turn_we;
    logic cast_we;
    logic piece_we;
    logic ep_we;
  } fill_wr_t;

endpackage

// File: rtl/zkt_gen.sv
// ----------------------------------------------------------------------------
// zkt_gen
// Park-Miller minimal standard step, 16807 * x mod (2^31 - 1), as a
// registered multiply, then a registered Mersenne fold and correction.
// ----------------------------------------------------------------------------
module zkt_gen (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic [30:0] load_value,
  input  logic        step,
  output logic [30:0] value,
  output logic        done
);

  logic [45:0] prod;
  logic        degen;
  logic        pend;
  logic [31:0] fold;
  logic [31:0] fold_red;
  logic [30:0] value_next;

  // Zero and the modulus itself both land on the modulus, as zero does in the Schrage form
  always_comb begin
    fold     = {1'b0, prod[30:0]} + {17'd0, prod[45:31]};
    fold_red = (fold >= {1'b0, zkt_pkg::MS_M}) ? fold - {1'b0, zkt_pkg::MS_M} : fold;
    value_next = degen ? zkt_pkg::MS_M : fold_red[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= 31'd1;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= pend;
      if (load) begin
        value <= load_value;
      end else if (pend) begin
        value <= value_next;
      end
      pend <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      prod  <= 46'(value) * 46'(zkt_pkg::MS_A);
      degen <= (value == 31'd0) || (value == zkt_pkg::MS_M);
    end
  end

endmodule

// File: rtl/zkt_ram.sv
// ----------------------------------------------------------------------------
// zkt_ram
// Simple dual-port key store: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module zkt_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);

  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/zkt_fill.sv
// ----------------------------------------------------------------------------
// zkt_fill
// Fill sequencer: draws three generator values per key and walks the tables
// in fill order, turn key, then castling and piece keys per side and square,
// then en-passant keys.
// ----------------------------------------------------------------------------
module zkt_fill #(
  parameter int NUM_SQUARES     = zkt_pkg::NUM_SQUARES_DEF,
  parameter int NUM_PIECE_TYPES = zkt_pkg::NUM_PIECE_TYPES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [30:0]        rnd,
  input  logic               rnd_done,
  output logic               step,
  output logic               busy,
  output logic               filled,
  output zkt_pkg::fill_wr_t  wr,
  output logic [63:0]        key,
  output logic [$clog2(2*NUM_PIECE_TYPES*NUM_SQUARES)-1:0] piece_addr,
  output logic [$clog2(2*NUM_SQUARES)-1:0]                 cast_addr,
  output logic [((NUM_SQUARES > 1) ? $clog2(NUM_SQUARES) : 1)-1:0] ep_addr
);

  localparam int SQW = (NUM_SQUARES > 1) ? $clog2(NUM_SQUARES) : 1;
  localparam int KW  = $clog2(NUM_PIECE_TYPES + 1);
  localparam int PAW = $clog2(2 * NUM_PIECE_TYPES * NUM_SQUARES);
  localparam int CAW = $clog2(2 * NUM_SQUARES);

  zkt_pkg::fill_state_t state, state_next;
  zkt_pkg::fill_phase_t phase;

  logic [1:0]     rcnt;
  logic [30:0]    r1;
  logic [30:0]    r2;
  logic [1:0]     r3;
  logic           side;
  logic [SQW-1:0] sq;
  logic [KW-1:0]  slot;
  logic           sq_last;
  logic           slot_last;
  logic           fill_last;
  logic [KW-1:0]  ptype;

  assign sq_last   = (sq == SQW'(NUM_SQUARES - 1));
  assign slot_last = (slot == KW'(NUM_PIECE_TYPES));
  assign fill_last = (phase == zkt_pkg::PH_EP) && sq_last;
  assign ptype     = slot - KW'(1);

  // Keys are r1 ^ (r2 << 31) ^ (r3 << 62); the fields do not overlap
  assign key = {r3, r2, r1};

  assign cast_addr  = CAW'(side) * CAW'(NUM_SQUARES) + CAW'(sq);
  assign piece_addr = (PAW'(side) * PAW'(NUM_PIECE_TYPES) + PAW'(ptype))
                      * PAW'(NUM_SQUARES) + PAW'(sq);
  assign ep_addr    = sq;

  always_comb begin
    state_next = state;
    case (state)
      zkt_pkg::FILL_IDLE:  if (start) state_next = zkt_pkg::FILL_STEP;
      zkt_pkg::FILL_STEP:  state_next = zkt_pkg::FILL_WAIT;
      zkt_pkg::FILL_WAIT: begin
        if (rnd_done) begin
          state_next = (rcnt == 2'd2) ? zkt_pkg::FILL_STORE : zkt_pkg::FILL_STEP;
        end
      end
      zkt_pkg::FILL_STORE: state_next = fill_last ? zkt_pkg::FILL_IDLE : zkt_pkg::FILL_STEP;
      default:             state_next = zkt_pkg::FILL_IDLE;
    endcase
  end

  always_comb begin
    step        = (state == zkt_pkg::FILL_STEP);
    busy        = (state != zkt_pkg::FILL_IDLE);
    wr.turn_we  = (state == zkt_pkg::FILL_STORE) && (phase == zkt_pkg::PH_TURN);
    wr.cast_we  = (state == zkt_pkg::FILL_STORE) && (phase == zkt_pkg::PH_MAIN)
                  && (slot == '0);
    wr.piece_we = (state == zkt_pkg::FILL_STORE) && (phase == zkt_pkg::PH_MAIN)
                  && (slot != '0);
    wr.ep_we    = (state == zkt_pkg::FILL_STORE) && (phase == zkt_pkg::PH_EP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= zkt_pkg::FILL_IDLE;
      phase  <= zkt_pkg::PH_TURN;
      rcnt   <= 2'd0;
      side   <= 1'b0;
      sq     <= '0;
      slot   <= '0;
      filled <= 1'b0;
    end else begin
      state <= state_next;
      if (state == zkt_pkg::FILL_WAIT && rnd_done) begin
        rcnt <= rcnt + 2'd1;
      end
      if (state == zkt_pkg::FILL_STORE) begin
        rcnt <= 2'd0;
        case (phase)
          zkt_pkg::PH_TURN: phase <= zkt_pkg::PH_MAIN;
          zkt_pkg::PH_MAIN: begin
            if (slot_last) begin
              slot <= '0;
              if (sq_last) begin
                sq <= '0;
                if (side) begin
                  phase <= zkt_pkg::PH_EP;
                end
                side <= ~side;
              end else begin
                sq <= sq + SQW'(1);
              end
            end else begin
              slot <= slot + KW'(1);
            end
          end
          zkt_pkg::PH_EP: begin
            if (sq_last) begin
              filled <= 1'b1;
            end else begin
              sq <= sq + SQW'(1);
            end
          end
          default: phase <= zkt_pkg::PH_TURN;
        endcase
      end
    end
  end

  // Hold each generator draw until the key is complete
  always_ff @(posedge clk) begin
    if (state == zkt_pkg::FILL_WAIT && rnd_done) begin
      case (rcnt)
        2'd0:    r1 <= rnd;
        2'd1:    r2 <= rnd;
        default: r3 <= rnd[1:0];
      endcase
    end
  end

endmodule

// File: rtl/zobrist_key_table_minstd.sv
// ----------------------------------------------------------------------------
// zobrist_key_table_minstd
// Zobrist key tables filled once from a minimal standard generator, with a
// streaming lookup port returning piece, castling, en-passant and side keys.
// ----------------------------------------------------------------------------
// Send a fill item (tuser low) once after reset: the block then draws three
// generator values per key and writes the side key, the castling and piece
// keys per side and square, then the en-passant keys. Each draw is one
// generator step (multiply, then fold), and each key ends in a write;
// there are 1 + 2*NUM_SQUARES*(NUM_PIECE_TYPES+1) + NUM_SQUARES keys,
// 2433 at the default sizes, and s_axis_tready is low while the fill
// runs. Further fill items are taken and ignored. Lookup items (tuser
// high) are taken one per cycle while the result stream does not stall;
// each passes a key store read, then the output register. A lookup before the
// fill returns zero keys with tuser low; an out-of-range square or piece
// type returns zero for the keys that use it. Write the seed only while no
// fill is running; once the tables are filled it no longer has any effect.
// ----------------------------------------------------------------------------
module zobrist_key_table_minstd #(
  parameter int NUM_SQUARES     = zkt_pkg::NUM_SQUARES_DEF,
  parameter int NUM_PIECE_TYPES = zkt_pkg::NUM_PIECE_TYPES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // Seed register
  input  logic         seed_we,
  input  logic [30:0]  seed_wdata,
  // Input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // side_index[0], piece_type[3:1], square_index[10:4]
  input  logic         s_axis_tuser,   // op[0]
  // Result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata,   // piece_key[63:0], castling_key[127:64],
                                       // enpassant_key[191:128], side_to_move_key[255:192]
  output logic         m_axis_tuser    // ready_res[0]
);

  localparam int SQW = (NUM_SQUARES > 1) ? $clog2(NUM_SQUARES) : 1;
  localparam int TW  = (NUM_PIECE_TYPES > 1) ? $clog2(NUM_PIECE_TYPES) : 1;
  localparam int PAW = $clog2(2 * NUM_PIECE_TYPES * NUM_SQUARES);
  localparam int CAW = $clog2(2 * NUM_SQUARES);

  // Input fields
  logic           in_side;
  logic [2:0]     in_type;
  logic [6:0]     in_sq;
  logic [TW-1:0]  type_l;
  logic [SQW-1:0] sq_l;
  logic           accept;
  logic           lookup;

  // Fill side
  logic              fill_start;
  logic              fill_busy;
  logic              filled;
  logic              gen_step;
  logic              gen_done;
  logic [30:0]       gen_value;
  zkt_pkg::fill_wr_t wr;
  logic [63:0]       fill_key;
  logic [PAW-1:0]    fill_piece_addr;
  logic [CAW-1:0]    fill_cast_addr;
  logic [SQW-1:0]    fill_ep_addr;
  logic [63:0]       turn_key;

  // Lookup side
  logic [PAW-1:0] rd_piece_addr;
  logic [CAW-1:0] rd_cast_addr;
  logic [63:0]    piece_rd;
  logic [63:0]    cast_rd;
  logic [63:0]    ep_rd;
  logic           p1_valid;
  logic           p1_filled;
  logic           p1_sq_ok;
  logic           p1_type_ok;
  logic           p1_move;
  logic           out_valid;
  logic [255:0]   out_data;
  logic           out_ready_res;

  assign in_side = s_axis_tdata[0];
  assign in_type = s_axis_tdata[3:1];
  assign in_sq   = s_axis_tdata[10:4];
  assign type_l  = TW'(in_type);
  assign sq_l    = SQW'(in_sq);

  // Take a lookup whenever the read stage is empty or moving on; hold off
  // everything while the fill walks the tables
  assign p1_move       = p1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !fill_busy && (!p1_valid || p1_move);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign lookup        = accept && (s_axis_tuser == zkt_pkg::OP_LOOKUP);
  assign fill_start    = accept && (s_axis_tuser == zkt_pkg::OP_FILL) && !filled;

  zkt_gen u_gen (
    .clk        (clk),
    .rst        (rst),
    .load       (seed_we && !filled && !fill_busy),
    .load_value (seed_wdata),
    .step       (gen_step),
    .value      (gen_value),
    .done       (gen_done)
  );

  zkt_fill #(
    .NUM_SQUARES     (NUM_SQUARES),
    .NUM_PIECE_TYPES (NUM_PIECE_TYPES)
  ) u_fill (
    .clk        (clk),
    .rst        (rst),
    .start      (fill_start),
    .rnd        (gen_value),
    .rnd_done   (gen_done),
    .step       (gen_step),
    .busy       (fill_busy),
    .filled     (filled),
    .wr         (wr),
    .key        (fill_key),
    .piece_addr (fill_piece_addr),
    .cast_addr  (fill_cast_addr),
    .ep_addr    (fill_ep_addr)
  );

  // Side-to-move key is a single word
  always_ff @(posedge clk) begin
    if (wr.turn_we) begin
      turn_key <= fill_key;
    end
  end

  assign rd_cast_addr  = CAW'(in_side) * CAW'(NUM_SQUARES) + CAW'(sq_l);
  assign rd_piece_addr = (PAW'(in_side) * PAW'(NUM_PIECE_TYPES) + PAW'(type_l))
                         * PAW'(NUM_SQUARES) + PAW'(sq_l);

  zkt_ram #(
    .DEPTH (2 * NUM_PIECE_TYPES * NUM_SQUARES),
    .AW    (PAW)
  ) u_piece_ram (
    .clk   (clk),
    .we    (wr.piece_we),
    .waddr (fill_piece_addr),
    .wdata (fill_key),
    .re    (lookup),
    .raddr (rd_piece_addr),
    .rdata (piece_rd)
  );

  zkt_ram #(
    .DEPTH (2 * NUM_SQUARES),
    .AW    (CAW)
  ) u_cast_ram (
    .clk   (clk),
    .we    (wr.cast_we),
    .waddr (fill_cast_addr),
    .wdata (fill_key),
    .re    (lookup),
    .raddr (rd_cast_addr),
    .rdata (cast_rd)
  );

  zkt_ram #(
    .DEPTH (NUM_SQUARES),
    .AW    (SQW)
  ) u_ep_ram (
    .clk   (clk),
    .we    (wr.ep_we),
    .waddr (fill_ep_addr),
    .wdata (fill_key),
    .re    (lookup),
    .raddr (sq_l),
    .rdata (ep_rd)
  );

  // Read stage: the store data registers hold while this stage stalls,
  // since no new read is issued until it moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (lookup) begin
      p1_valid <= 1'b1;
    end else if (p1_move) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup) begin
      p1_filled  <= filled;
      p1_sq_ok   <= (9'(in_sq) < 9'(NUM_SQUARES));
      p1_type_ok <= (5'(in_type) < 5'(NUM_PIECE_TYPES));
    end
  end

  // Output register: zero every key that the table state or the indices rule out
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p1_move) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      out_data[63:0]    <= (p1_filled && p1_sq_ok && p1_type_ok) ? piece_rd : 64'd0;
      out_data[127:64]  <= (p1_filled && p1_sq_ok) ? cast_rd : 64'd0;
      out_data[191:128] <= (p1_filled && p1_sq_ok) ? ep_rd : 64'd0;
      out_data[255:192] <= p1_filled ? turn_key : 64'd0;
      out_ready_res     <= p1_filled;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_ready_res;

endmodule

// File: tb/sv/zobrist_key_table_minstd_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zobrist_key_table_minstd_tb
// Self-checking bench for the Zobrist key table. A short stimulus table covers
// lookups before the fill, seed writes at both ends of the range and outside
// it, the fill itself, a repeated fill and lookups at the corner squares and
// piece types. A random run of lookups with some repeated fills follows, under
// three idling patterns and one long receiver stall. Each result is compared
// with a key table that the bench fills itself from the same generator.
// ----------------------------------------------------------------------------
module zobrist_key_table_minstd_tb;
  import zkt_pkg::*;

  localparam int SQUARES     = NUM_SQUARES_DEF;
  localparam int PIECE_TYPES = NUM_PIECE_TYPES_DEF;

  // Park-Miller constants, with Schrage's split of the modulus
  localparam longint MINSTD_MULT = 16807;
  localparam longint MINSTD_MOD  = 2147483647;
  localparam longint SCHRAGE_Q   = MINSTD_MOD / MINSTD_MULT;
  localparam longint SCHRAGE_R   = MINSTD_MOD % MINSTD_MULT;

  localparam logic [30:0] SEED_MIN = 31'd1;
  localparam logic [30:0] SEED_MAX = 31'h7fff_fffe;
  localparam logic [30:0] SEED_FIX = 31'h7fff_ffff;  // fixed point of the step

  localparam int ITEMS_PER_PHASE = 150;
  localparam int FILL_NOISE_PCT  = 6;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_CYCLES     = 300;
  // the limit covers the fill and the worst idling and stalls
  localparam int CYCLE_LIMIT     = 250000;

  // One result transfer: tdata followed by tuser, most significant field first
  typedef struct packed {
    logic [63:0] side_key;
    logic [63:0] ep_key;
    logic [63:0] castle_key;
    logic [63:0] piece_key;
    logic        ready;
  } key_result_t;

  localparam key_result_t NO_KEYS = '0;

  typedef enum logic [1:0] {
    ROW_ITEM,       // offer one input transfer
    ROW_SEED,       // write the seed given in the row
    ROW_SEED_RAND   // write a random seed from the legal range
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        op;
    logic        side;
    logic [2:0]  ptype;
    logic [6:0]  square;
    logic [30:0] seed;
    logic        lit_valid;  // expected result typed into the row
    key_result_t lit;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  // Lookups before the fill read all zero whatever the seed. After the fill
  // the seed register no longer reaches the generator, so the later seed
  // rows must leave every key unchanged.
  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{ROW_ITEM,      OP_LOOKUP, 1'b0, 3'd0, 7'd0,   31'd0,    1'b1, NO_KEYS},
    '{ROW_SEED,      OP_FILL,   1'b0, 3'd0, 7'd0,   SEED_MAX, 1'b0, NO_KEYS},
    '{ROW_ITEM,      OP_LOOKUP, 1'b1, 3'd7, 7'd127, 31'd0,    1'b1, NO_KEYS},
    '{ROW_SEED,      OP_FILL,   1'b0, 3'd0, 7'd0,   31'd0,    1'b0, NO_KEYS},
    '{ROW_ITEM,      OP_LOOKUP, 1'b0, 3'd5, 7'd85,  31'd0,    1'b1, NO_KEYS},
    '{ROW_SEED,      OP_FILL,   1'b0, 3'd0, 7'd0,   SEED_FIX, 1'b0, NO_KEYS},
    '{ROW_ITEM,      OP_LOOKUP, 1'b1, 3'd2, 7'd42,  31'd0,    1'b1, NO_KEYS},
    '{ROW_SEED,      OP_FILL,   1'b0, 3'd0, 7'd0,   SEED_MIN, 1'b0, NO_KEYS},
    '{ROW_SEED_RAND, OP_FILL,   1'b0, 3'd0, 7'd0,   31'd0,    1'b0, NO_KEYS},
    '{ROW_ITEM,      OP_FILL,   1'b0, 3'd0, 7'd0,   31'd0,    1'b0, NO_KEYS},
    '{ROW_ITEM,      OP_LOOKUP, 1'b0, 3'd0, 7'd0,   31'd0,    1'b0, NO_KEYS},
    '{ROW_ITEM,      OP_LOOKUP, 1'b1, 3'd7, 7'd127, 31'd0,    1'b0, NO_KEYS},
    '{ROW_ITEM,      OP_LOOKUP, 1'b0, 3'd7, 7'd0,   31'd0,    1'b0, NO_KEYS},
    '{ROW_ITEM,      OP_LOOKUP, 1'b1, 3'd0, 7'd127, 31'd0,    1'b0, NO_KEYS},
    '{ROW_ITEM,      OP_FILL,   1'b1, 3'd7, 7'd127, 31'd0,    1'b0, NO_KEYS},
    '{ROW_ITEM,      OP_LOOKUP, 1'b0, 3'd3, 7'd64,  31'd0,    1'b0, NO_KEYS},
    '{ROW_SEED,      OP_FILL,   1'b0, 3'd0, 7'd0,   SEED_MAX, 1'b0, NO_KEYS},
    '{ROW_ITEM,      OP_LOOKUP, 1'b1, 3'd4, 7'd1,   31'd0,    1'b0, NO_KEYS},
    '{ROW_SEED,      OP_FILL,   1'b0, 3'd0, 7'd0,   31'd0,    1'b0, NO_KEYS},
    '{ROW_ITEM,      OP_LOOKUP, 1'b0, 3'd6, 7'd126, 31'd0,    1'b0, NO_KEYS},
    '{ROW_SEED,      OP_FILL,   1'b0, 3'd0, 7'd0,   SEED_FIX, 1'b0, NO_KEYS},
    '{ROW_ITEM,      OP_LOOKUP, 1'b1, 3'd1, 7'd63,  31'd0,    1'b0, NO_KEYS},
    '{ROW_SEED,      OP_FILL,   1'b0, 3'd0, 7'd0,   SEED_MIN, 1'b0, NO_KEYS},
    '{ROW_ITEM,      OP_LOOKUP, 1'b0, 3'd0, 7'd127, 31'd0,    1'b0, NO_KEYS},
    '{ROW_ITEM,      OP_LOOKUP, 1'b1, 3'd7, 7'd0,   31'd0,    1'b0, NO_KEYS}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         seed_we = 1'b0;
  logic [30:0]  seed_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata = '0;   // side_index[0], piece_type[3:1], square_index[10:4]
  logic         s_axis_tuser = 1'b0; // op[0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [255:0] m_axis_tdata;        // piece_key[63:0], castling_key[127:64],
                                     // enpassant_key[191:128], side_to_move_key[255:192]
  logic         m_axis_tuser;        // ready_res[0]

  // Bench-side copy of the block state
  logic [63:0] piece_tab  [0:2*PIECE_TYPES*SQUARES-1];
  logic [63:0] castle_tab [0:2*SQUARES-1];
  logic [63:0] ep_tab     [0:SQUARES-1];
  logic [63:0] turn_word;
  logic [30:0] gen_value   = SEED_MIN;
  bit          tables_filled = 1'b0;

  key_result_t pending_keys [$];   // lookups accepted, result not yet seen
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;
  bit          hold_go  = 1'b0;
  logic        hold_off = 1'b0;

  zobrist_key_table_minstd #(
    .NUM_SQUARES     (SQUARES),
    .NUM_PIECE_TYPES (PIECE_TYPES)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .seed_we       (seed_we),
    .seed_wdata    (seed_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Key prediction
  // --------------------------------------------------------------------------

  // One generator step, x' = 16807 * x mod (2^31 - 1), without overflow
  function automatic logic [30:0] minstd_next(input logic [30:0] x);
    longint hi;
    longint lo;
    longint t;
    hi = longint'(x) / SCHRAGE_Q;
    lo = longint'(x) % SCHRAGE_Q;
    t  = MINSTD_MULT * lo - SCHRAGE_R * hi;
    if (t <= 0) t += MINSTD_MOD;
    return t[30:0];
  endfunction

  // Three successive draws make one key; the top draw keeps only its two
  // low bits after truncation to 64 bits
  function automatic logic [63:0] draw_key();
    logic [63:0] r1;
    logic [63:0] r2;
    logic [63:0] r3;
    gen_value = minstd_next(gen_value);
    r1 = {33'b0, gen_value};
    gen_value = minstd_next(gen_value);
    r2 = {33'b0, gen_value};
    gen_value = minstd_next(gen_value);
    r3 = {33'b0, gen_value};
    return r1 ^ (r2 << 31) ^ (r3 << 62);
  endfunction

  // Walk the tables in the block's fill order
  function automatic void fill_key_tables();
    int s;
    int sq;
    int t;
    turn_word = draw_key();
    for (s = 0; s < 2; s++) begin
      for (sq = 0; sq < SQUARES; sq++) begin
        castle_tab[s*SQUARES + sq] = draw_key();
        for (t = 0; t < PIECE_TYPES; t++) begin
          piece_tab[(s*PIECE_TYPES + t)*SQUARES + sq] = draw_key();
        end
      end
    end
    for (sq = 0; sq < SQUARES; sq++) begin
      ep_tab[sq] = draw_key();
    end
    tables_filled = 1'b1;
  endfunction

  function automatic key_result_t predict_lookup(input logic side, input logic [2:0] ptype,
                                                 input logic [6:0] sq);
    key_result_t r;
    r = NO_KEYS;
    if (tables_filled) begin
      r.side_key = turn_word;
      if (int'(sq) < SQUARES) begin
        r.castle_key = castle_tab[int'(side)*SQUARES + int'(sq)];
        r.ep_key     = ep_tab[int'(sq)];
        if (int'(ptype) < PIECE_TYPES)
          r.piece_key = piece_tab[(int'(side)*PIECE_TYPES + int'(ptype))*SQUARES + int'(sq)];
      end
    end
    r.ready = tables_filled;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Offer one transfer, hold it until taken, then predict its result.
  // tvalid is left high so back-to-back transfers need no extra assignment.
  task automatic send_item(input logic op, input logic side, input logic [2:0] ptype,
                           input logic [6:0] sq, input logic lit_valid,
                           input key_result_t lit);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, sq, ptype, side};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    if (op == OP_FILL) begin
      // a repeated fill leaves tables and generator alone
      if (!tables_filled) fill_key_tables();
    end else begin
      pending_keys.push_back(lit_valid ? lit : predict_lookup(side, ptype, sq));
    end
  endtask

  // Drop tvalid and wait until every result is in and the block has settled
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [30:0] value);
    drain_results();
    seed_we    <= 1'b1;
    seed_wdata <= value;
    @(posedge clk);
    seed_we <= 1'b0;
    // the generator follows the register only until the tables are filled
    if (!tables_filled) gen_value = value;
  endtask

  // --------------------------------------------------------------------------
  // Result side: check each transfer, then decide tready for the next cycle
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_mon
    key_result_t got;
    key_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata, m_axis_tuser};
      if (pending_keys.size() == 0) begin
        report_mismatch("result with no lookup pending", got.piece_key, '0);
      end else begin
        want = pending_keys.pop_front();
        if (got.piece_key !== want.piece_key)
          report_mismatch("piece_key", got.piece_key, want.piece_key);
        if (got.castle_key !== want.castle_key)
          report_mismatch("castling_key", got.castle_key, want.castle_key);
        if (got.ep_key !== want.ep_key)
          report_mismatch("enpassant_key", got.ep_key, want.ep_key);
        if (got.side_key !== want.side_key)
          report_mismatch("side_to_move_key", got.side_key, want.side_key);
        if (got.ready !== want.ready)
          report_mismatch("ready_res", 64'(got.ready), 64'(want.ready));
      end
    end
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver stall: the output register fills and the input backs up
  initial begin : hold_ctl
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("zobrist_key_table_minstd_tb NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int row;
    int phase;
    int n;
    logic [30:0] seed_pick;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Stimulus table, mild idling on both sides
    send_idle_pct = 20;
    recv_idle_pct = 20;
    for (row = 0; row < DIR_ROWS; row++) begin
      case (dir_rows[row].kind)
        ROW_SEED: begin
          write_seed(dir_rows[row].seed);
        end
        ROW_SEED_RAND: begin
          write_seed(31'($urandom_range(SEED_MAX, SEED_MIN)));
        end
        default: begin
          send_item(dir_rows[row].op, dir_rows[row].side, dir_rows[row].ptype,
                    dir_rows[row].square, dir_rows[row].lit_valid, dir_rows[row].lit);
        end
      endcase
    end

    // Random lookups with a sprinkling of ignored fills. Phase 0 starves the
    // sender less than the receiver, phase 1 the reverse, phase 2 runs flat
    // out apart from one long receiver hold-off.
    for (phase = 0; phase < 3; phase++) begin
      case ($urandom_range(4))
        0:       seed_pick = SEED_MIN;
        1:       seed_pick = SEED_MAX;
        2:       seed_pick = '0;
        3:       seed_pick = SEED_FIX;
        default: seed_pick = 31'($urandom);
      endcase
      write_seed(seed_pick);
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 63 : 0;
      recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 37 : 0;
      if (phase == 2) hold_go = 1'b1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(($urandom_range(99) < FILL_NOISE_PCT) ? OP_FILL : OP_LOOKUP,
                  1'($urandom_range(1)), 3'($urandom_range(7)), 7'($urandom_range(127)),
                  1'b0, NO_KEYS);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("zobrist_key_table_minstd_tb OK");
    end else begin
      $display("zobrist_key_table_minstd_tb NOT OK");
    end
    $finish;
  end

endmodule
